// ===== rtl/cep_pkg.sv =====
// Charge enable policy package: register indexes, mode and decision codes, limits.
// Used by the channel interfaces and by charge_enable_policy_top.
package cep_pkg;

  localparam int unsigned LevelW = 8;
  localparam int unsigned LimitW = 7;
  localparam int unsigned CfgDataW = 7;

  localparam logic [LimitW-1:0] LevelFull = LimitW'(100);
  localparam logic signed [LevelW-1:0] LevelFullS = LevelW'(100);
  localparam logic signed [LevelW-1:0] LevelMinimum = LevelW'(5);

  typedef enum logic [1:0] {
    REG_CHARGE_MODE  = 2'd0,
    REG_LOW_LIMIT    = 2'd1,
    REG_HIGH_LIMIT   = 2'd2,
    REG_CONTROL_AVAIL = 2'd3
  } cfg_reg_e;

  typedef enum logic [1:0] {
    MODE_DISABLE     = 2'd0,
    MODE_ENABLE      = 2'd1,
    MODE_THRESH      = 2'd2,
    MODE_THRESH_FULL = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    DEC_UNKNOWN  = 2'd0,
    DEC_ENABLED  = 2'd1,
    DEC_DISABLED = 2'd2
  } dec_e;

  // force request codes; the fourth code is ignored like FORCE_NONE
  localparam logic [1:0] FORCE_NONE = 2'd0;
  localparam logic [1:0] FORCE_ON   = 2'd1;
  localparam logic [1:0] FORCE_OFF  = 2'd2;

  // clamp a limit register to 100
  function automatic logic [LimitW-1:0] clamp_limit(input logic [LimitW-1:0] v);
    clamp_limit = (v > LevelFull) ? LevelFull : v;
  endfunction

endpackage

// ===== rtl/cep_if.sv =====
// Valid/ready channel interfaces for the charge enable policy block:
// snapshot input, decision output and configuration write. Depends on cep_pkg.
interface cep_in_if import cep_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic                     cable_disconnected;
  logic                     status_full;
  logic signed [LevelW-1:0] level_percent;
  logic [1:0]               force_request;

  modport source (output valid, cable_disconnected, status_full, level_percent,
                  force_request, input ready);
  modport sink (input valid, cable_disconnected, status_full, level_percent,
                force_request, output ready);
endinterface

interface cep_out_if;
  logic valid;
  logic ready;
  logic charge_allowed;
  logic decision_changed;
  logic forced_active;
  logic full_seen_out;

  modport source (output valid, charge_allowed, decision_changed, forced_active,
                  full_seen_out, input ready);
  modport sink (input valid, charge_allowed, decision_changed, forced_active,
                full_seen_out, output ready);
endinterface

interface cep_cfg_if import cep_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [1:0]          idx;
  logic [CfgDataW-1:0] wdata;

  modport source (output valid, idx, wdata, input ready);
  modport sink (input valid, idx, wdata, output ready);
endinterface

// ===== rtl/charge_enable_policy_top.sv =====
// Flow: an accepted snapshot waits in the input register and moves into the result
//   register once that is empty or being read; its result is then offered.
// Throughput: one snapshot per cycle; the result register and input register
//   stall only when the result is not taken.
// Reset: asynchronous, active low; configuration registers go to their defaults,
//   valid flags and both latches clear, and the last decision reads unknown.
module charge_enable_policy_top import cep_pkg::*; (
  input logic  clk_i,
  input logic  rst_ni,
  cep_in_if.sink    in_i,
  cep_cfg_if.sink   cfg_i,
  cep_out_if.source out_o
);

  // configuration registers
  mode_e             mode_q;
  logic [LimitW-1:0] low_q;
  logic [LimitW-1:0] high_q;
  logic              ctrl_avail_q;

  // policy state
  dec_e decision_q, decision_d;
  logic full_seen_q, full_seen_d;
  logic forced_q, forced_d;

  // input stage
  logic                     s1_valid_q;
  logic                     s1_unplugged_q;
  logic                     s1_stat_full_q;
  logic signed [LevelW-1:0] s1_level_q;
  logic [1:0]               s1_req_q;

  // result stage
  logic out_valid_q;
  logic out_allowed_q, out_changed_q, out_forced_q, out_full_q;

  logic s1_fire, in_fire, cfg_fire;
  logic [LimitW-1:0] lo, hi_clamp, hi;
  logic signed [LevelW-1:0] lo_s, hi_s;
  logic forced_1, full_1;
  dec_e next_dec;

  assign s1_fire  = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || s1_fire;
  assign in_fire  = in_i.valid && in_i.ready;
  // a write waits until no snapshot sits in the input stage
  assign cfg_i.ready = !s1_valid_q;
  assign cfg_fire = cfg_i.valid && cfg_i.ready;

  always_comb begin
    lo       = clamp_limit(low_q);
    hi_clamp = clamp_limit(high_q);
    hi       = (hi_clamp <= lo) ? LevelFull : hi_clamp;
    lo_s     = LevelW'({1'b0, lo});
    hi_s     = LevelW'({1'b0, hi});

    // force request first
    forced_1 = forced_q;
    full_1   = full_seen_q;
    if (s1_req_q == FORCE_ON) begin
      if (!forced_q) begin
        forced_1 = 1'b1;
        full_1   = 1'b0;
      end
    end else if (s1_req_q == FORCE_OFF) begin
      forced_1 = 1'b0;
    end

    next_dec    = decision_q;
    full_seen_d = full_1;
    if (s1_unplugged_q) begin
      full_seen_d = 1'b0;
      next_dec    = (mode_q == MODE_DISABLE) ? DEC_DISABLED : DEC_ENABLED;
    end else begin
      if (s1_stat_full_q || (s1_level_q >= LevelFullS)) full_seen_d = 1'b1;
      unique case (mode_q)
        MODE_DISABLE: next_dec = DEC_DISABLED;
        MODE_ENABLE:  next_dec = DEC_ENABLED;
        MODE_THRESH, MODE_THRESH_FULL: begin
          if (mode_q == MODE_THRESH_FULL && !full_seen_d) begin
            next_dec = DEC_ENABLED;
          end else if (s1_level_q <= lo_s) begin
            next_dec = DEC_ENABLED;
          end else if (s1_level_q >= hi_s) begin
            next_dec = DEC_DISABLED;
          end
        end
        default: next_dec = decision_q;
      endcase
    end

    // override ends on unplug or full
    forced_d = forced_1 && !(s1_unplugged_q || full_seen_d);
    if (forced_d) next_dec = DEC_ENABLED;

    if (s1_level_q < LevelMinimum) next_dec = DEC_ENABLED;

    if (next_dec != DEC_DISABLED || !ctrl_avail_q) next_dec = DEC_ENABLED;
    decision_d = next_dec;
  end

  // configuration and policy state; a write never meets a moving snapshot
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= MODE_ENABLE;
      low_q        <= LimitW'(87);
      high_q       <= LimitW'(90);
      ctrl_avail_q <= 1'b1;
      decision_q   <= DEC_UNKNOWN;
      full_seen_q  <= 1'b0;
      forced_q     <= 1'b0;
    end else if (cfg_fire) begin
      unique case (cfg_reg_e'(cfg_i.idx))
        REG_CHARGE_MODE: begin
          if (mode_e'(cfg_i.wdata[1:0]) != mode_q) begin
            mode_q      <= mode_e'(cfg_i.wdata[1:0]);
            full_seen_q <= 1'b0;
            forced_q    <= 1'b0;
          end
        end
        REG_LOW_LIMIT:     low_q        <= cfg_i.wdata[LimitW-1:0];
        REG_HIGH_LIMIT:    high_q       <= cfg_i.wdata[LimitW-1:0];
        REG_CONTROL_AVAIL: ctrl_avail_q <= cfg_i.wdata[0];
        default: ;
      endcase
    end else if (s1_fire) begin
      decision_q  <= decision_d;
      full_seen_q <= full_seen_d;
      forced_q    <= forced_d;
    end
  end

  // valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_i.ready) s1_valid_q <= in_fire;
      if (s1_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_unplugged_q <= in_i.cable_disconnected;
      s1_stat_full_q <= in_i.status_full;
      s1_level_q     <= in_i.level_percent;
      s1_req_q       <= in_i.force_request;
    end
    if (s1_fire) begin
      out_allowed_q <= (decision_d == DEC_ENABLED);
      out_changed_q <= (decision_d != decision_q);
      out_forced_q  <= forced_d;
      out_full_q    <= full_seen_d;
    end
  end

  assign out_o.valid            = out_valid_q;
  assign out_o.charge_allowed   = out_allowed_q;
  assign out_o.decision_changed = out_changed_q;
  assign out_o.forced_active    = out_forced_q;
  assign out_o.full_seen_out    = out_full_q;

`ifndef SYNTHESIS
  // once decided, the decision never goes back to unknown
  a_dec_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    decision_q != DEC_UNKNOWN |=> decision_q != DEC_UNKNOWN)
    else $error("decision returned to unknown");

  // a moved snapshot always lands in the result register
  a_s1_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire |=> out_valid_q)
    else $error("result lost between stages");

  // the held result matches the stored decision
  a_out_matches_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_allowed_q == (decision_q == DEC_ENABLED)))
    else $error("result and stored decision disagree");

  // override cannot survive a full battery
  a_forced_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_forced_q && out_full_q))
    else $error("forced charging active with full latch set");
`endif

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking bench for charge_enable_policy_top: directed and random snapshots,
// register rewrites between phases, a scoreboard class that predicts every decision.
// Depends on rtl/cep_pkg.sv, rtl/cep_if.sv and rtl/charge_enable_policy_top.sv.
module tb_top;
  import cep_pkg::*;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned DrainCycles = 4;
  localparam int unsigned RandomItems = 500;
  // fourth force code, ignored by the block
  localparam logic [1:0] ForceUnused = 2'd3;

  typedef struct packed {
    logic                     unplugged;
    logic                     status_full;
    logic signed [LevelW-1:0] level;
    logic [1:0]               force_req;
  } snapshot_t;

  typedef struct packed {
    logic allowed;
    logic changed;
    logic forced;
    logic full_seen;
  } decision_t;

  class charge_scoreboard;
    mode_e            mode;
    logic [LimitW-1:0] low_limit;
    logic [LimitW-1:0] high_limit;
    logic             ctrl_avail;
    dec_e             last_dec;
    logic             full_seen;
    logic             forced_on;
    decision_t        expected_q[$];
    int unsigned      mismatches;

    function new();
      mode = MODE_ENABLE;
      low_limit = 87;
      high_limit = 90;
      ctrl_avail = 1'b1;
      last_dec = DEC_UNKNOWN;
      full_seen = 1'b0;
      forced_on = 1'b0;
      mismatches = 0;
    endfunction

    function void write_reg(cfg_reg_e idx, logic [CfgDataW-1:0] data);
      case (idx)
        REG_CHARGE_MODE: begin
          // only a real mode change drops both latches
          if (mode_e'(data[1:0]) != mode) begin
            mode = mode_e'(data[1:0]);
            full_seen = 1'b0;
            forced_on = 1'b0;
          end
        end
        REG_LOW_LIMIT:     low_limit = data[LimitW-1:0];
        REG_HIGH_LIMIT:    high_limit = data[LimitW-1:0];
        REG_CONTROL_AVAIL: ctrl_avail = data[0];
        default: ;
      endcase
    endfunction

    function void note_input(snapshot_t s);
      int        lvl;
      int        lo;
      int        hi;
      dec_e      nxt;
      decision_t exp;
      lvl = int'($signed(s.level));
      lo = (low_limit > LevelFull) ? int'(LevelFull) : int'(low_limit);
      hi = (high_limit > LevelFull) ? int'(LevelFull) : int'(high_limit);
      nxt = last_dec;

      if (s.force_req == FORCE_ON) begin
        if (!forced_on) begin
          forced_on = 1'b1;
          full_seen = 1'b0;
        end
      end else if (s.force_req == FORCE_OFF) begin
        forced_on = 1'b0;
      end

      if (hi <= lo) hi = int'(LevelFull);

      if (s.unplugged) begin
        full_seen = 1'b0;
        nxt = (mode == MODE_DISABLE) ? DEC_DISABLED : DEC_ENABLED;
      end else begin
        if (s.status_full || lvl >= int'(LevelFull)) full_seen = 1'b1;
        if (mode == MODE_DISABLE) begin
          nxt = DEC_DISABLED;
        end else if (mode == MODE_ENABLE) begin
          nxt = DEC_ENABLED;
        end else if (mode == MODE_THRESH_FULL && !full_seen) begin
          nxt = DEC_ENABLED;
        end else if (lvl <= lo) begin
          nxt = DEC_ENABLED;
        end else if (lvl >= hi) begin
          nxt = DEC_DISABLED;
        end
      end

      if (forced_on) begin
        if (s.unplugged || full_seen) forced_on = 1'b0;
        if (forced_on) nxt = DEC_ENABLED;
      end

      if (lvl < int'(LevelMinimum)) nxt = DEC_ENABLED;
      if (nxt != DEC_DISABLED || !ctrl_avail) nxt = DEC_ENABLED;

      exp.allowed = (nxt == DEC_ENABLED);
      exp.changed = (nxt != last_dec);
      exp.forced = forced_on;
      exp.full_seen = full_seen;
      last_dec = nxt;
      expected_q.push_back(exp);
    endfunction

    task report(string msg);
      mismatches++;
      $display("ERROR %0t: %s", $time, msg);
    endtask

    task check_result(decision_t got);
      decision_t exp;
      if (expected_q.size() == 0) begin
        report($sformatf("decision transaction with none pending: %b", got));
        return;
      end
      exp = expected_q.pop_front();
      if (got.allowed !== exp.allowed)
        report($sformatf("charge_allowed %b, expected %b", got.allowed, exp.allowed));
      if (got.changed !== exp.changed)
        report($sformatf("decision_changed %b, expected %b", got.changed, exp.changed));
      if (got.forced !== exp.forced)
        report($sformatf("forced_active %b, expected %b", got.forced, exp.forced));
      if (got.full_seen !== exp.full_seen)
        report($sformatf("full_seen_out %b, expected %b", got.full_seen, exp.full_seen));
    endtask
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic sink_ready = 1'b0;
  int unsigned cycle_cnt = 0;
  int unsigned stall_cnt = 0;
  int unsigned stall_style = 0;

  charge_scoreboard sb;
  int walk_level;
  logic walk_unplugged;
  int burst_left;
  int unsigned sent;

  cep_in_if  in_if ();
  cep_out_if out_if ();
  cep_cfg_if cfg_if ();

  assign out_if.ready = sink_ready;

  charge_enable_policy_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .cfg_i  (cfg_if),
    .out_o  (out_if)
  );

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // receiver: switches between always ready, coin flips and a fixed duty pattern
  always @(negedge clk_i) begin
    stall_cnt <= stall_cnt + 1;
    if (stall_cnt % 64 == 0) stall_style <= $urandom_range(0, 2);
    case (stall_style)
      0:       sink_ready <= 1'b1;
      1:       sink_ready <= 1'($urandom_range(0, 1));
      default: sink_ready <= (stall_cnt % 7) < 4;
    endcase
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && sink_ready)
      sb.check_result(decision_t'{out_if.charge_allowed, out_if.decision_changed,
                                  out_if.forced_active, out_if.full_seen_out});
  end

  function automatic snapshot_t snap(logic u, logic f, int lvl, logic [1:0] rq);
    snapshot_t s;
    s.unplugged = u;
    s.status_full = f;
    s.level = LevelW'(lvl);
    s.force_req = rq;
    return s;
  endfunction

  // mostly a plausible charge/discharge walk, some fully random snapshots
  function automatic snapshot_t next_snapshot();
    snapshot_t s;
    if ($urandom_range(0, 4) == 0) begin
      s.unplugged = 1'($urandom_range(0, 1));
      s.status_full = 1'($urandom_range(0, 1));
      s.level = LevelW'($urandom);
      s.force_req = 2'($urandom_range(0, 3));
      return s;
    end
    if ($urandom_range(0, 14) == 0) walk_unplugged = !walk_unplugged;
    if (walk_unplugged) walk_level -= $urandom_range(0, 3);
    else walk_level += $urandom_range(0, 3);
    if (walk_level > 100) walk_level = 100;
    if (walk_level < -1) walk_level = -1;
    s.unplugged = walk_unplugged;
    s.level = LevelW'(walk_level);
    s.status_full = (walk_level >= 100) || ($urandom_range(0, 19) == 0);
    case ($urandom_range(0, 19))
      0:       s.force_req = FORCE_ON;
      1:       s.force_req = FORCE_OFF;
      2:       s.force_req = ForceUnused;
      default: s.force_req = FORCE_NONE;
    endcase
    return s;
  endfunction

  function automatic logic [CfgDataW-1:0] pick_limit();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2:       return CfgDataW'(100 + $urandom_range(0, 27));
      3:       return CfgDataW'($urandom);
      default: return CfgDataW'($urandom_range(70, 99));
    endcase
  endfunction

  task automatic send_snapshot(snapshot_t s);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
        in_if.valid = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_if.valid = 1'b1;
    in_if.cable_disconnected = s.unplugged;
    in_if.status_full = s.status_full;
    in_if.level_percent = s.level;
    in_if.force_request = s.force_req;
    do @(posedge clk_i); while (!in_if.ready);
    sb.note_input(s);
    sent++;
    @(negedge clk_i);
  endtask

  // stop sending and let every pending decision come out
  task automatic drain();
    in_if.valid = 1'b0;
    while (sb.expected_q.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [CfgDataW-1:0] data);
    cfg_if.valid = 1'b1;
    cfg_if.idx = idx;
    cfg_if.wdata = data;
    do @(posedge clk_i); while (!cfg_if.ready);
    sb.write_reg(idx, data);
    @(negedge clk_i);
    cfg_if.valid = 1'b0;
  endtask

  task automatic random_config();
    if ($urandom_range(0, 3) != 0) write_reg(REG_CHARGE_MODE, CfgDataW'($urandom));
    if ($urandom_range(0, 1) != 0) write_reg(REG_LOW_LIMIT, pick_limit());
    if ($urandom_range(0, 1) != 0) write_reg(REG_HIGH_LIMIT, pick_limit());
    if ($urandom_range(0, 2) == 0)
      write_reg(REG_CONTROL_AVAIL,
                {(CfgDataW-1)'($urandom), 1'($urandom_range(0, 3) != 0)});
  endtask

  initial begin
    in_if.valid = 1'b0;
    in_if.cable_disconnected = 1'b0;
    in_if.status_full = 1'b0;
    in_if.level_percent = '0;
    in_if.force_request = FORCE_NONE;
    cfg_if.valid = 1'b0;
    cfg_if.idx = REG_CHARGE_MODE;
    cfg_if.wdata = '0;
    sb = new();
    walk_level = 80;
    walk_unplugged = 1'b0;
    burst_left = 0;
    sent = 0;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // reset settings: always enable
    send_snapshot(snap(1'b0, 1'b0, 50, FORCE_NONE));
    send_snapshot(snap(1'b0, 1'b0, -1, FORCE_NONE));
    send_snapshot(snap(1'b0, 1'b1, -128, ForceUnused));
    send_snapshot(snap(1'b0, 1'b0, 127, FORCE_NONE));
    send_snapshot(snap(1'b1, 1'b0, 100, FORCE_NONE));
    drain();

    // plain hysteresis between 20 and 80
    write_reg(REG_CHARGE_MODE, CfgDataW'(MODE_THRESH));
    write_reg(REG_LOW_LIMIT, CfgDataW'(20));
    write_reg(REG_HIGH_LIMIT, CfgDataW'(80));
    send_snapshot(snap(1'b0, 1'b0, 85, FORCE_NONE));
    send_snapshot(snap(1'b0, 1'b0, 50, FORCE_NONE));
    send_snapshot(snap(1'b0, 1'b0, 20, FORCE_NONE));
    send_snapshot(snap(1'b0, 1'b0, 50, FORCE_ON));
    send_snapshot(snap(1'b0, 1'b0, 90, FORCE_ON));
    send_snapshot(snap(1'b0, 1'b0, 90, FORCE_OFF));
    send_snapshot(snap(1'b0, 1'b0, 4, FORCE_NONE));
    send_snapshot(snap(1'b0, 1'b0, 5, FORCE_NONE));
    drain();

    // hysteresis after full, limits collapse so the upper one becomes 100
    write_reg(REG_CHARGE_MODE, CfgDataW'(MODE_THRESH_FULL));
    write_reg(REG_LOW_LIMIT, '0);
    write_reg(REG_HIGH_LIMIT, '0);
    send_snapshot(snap(1'b0, 1'b0, 95, FORCE_NONE));
    send_snapshot(snap(1'b0, 1'b1, 95, FORCE_NONE));
    send_snapshot(snap(1'b0, 1'b0, 100, FORCE_NONE));
    send_snapshot(snap(1'b0, 1'b0, 60, FORCE_ON));
    send_snapshot(snap(1'b0, 1'b1, 60, FORCE_NONE));
    send_snapshot(snap(1'b1, 1'b0, 60, FORCE_ON));
    drain();

    // rewriting the same mode keeps the latches; limits above 100 clamp
    write_reg(REG_CHARGE_MODE, CfgDataW'(MODE_THRESH_FULL));
    write_reg(REG_LOW_LIMIT, '1);
    write_reg(REG_HIGH_LIMIT, '1);
    send_snapshot(snap(1'b0, 1'b0, 100, FORCE_NONE));
    drain();

    // disable mode without and then with control
    write_reg(REG_CHARGE_MODE, CfgDataW'(MODE_DISABLE));
    write_reg(REG_CONTROL_AVAIL, '0);
    send_snapshot(snap(1'b0, 1'b0, 50, FORCE_NONE));
    send_snapshot(snap(1'b1, 1'b0, 50, FORCE_NONE));
    drain();
    write_reg(REG_CONTROL_AVAIL, CfgDataW'(1));
    send_snapshot(snap(1'b0, 1'b0, 50, FORCE_NONE));
    send_snapshot(snap(1'b0, 1'b0, 3, FORCE_OFF));
    send_snapshot(snap(1'b1, 1'b1, 50, FORCE_ON));
    drain();

    sent = 0;
    while (sent < RandomItems) begin
      random_config();
      repeat ($urandom_range(20, 60)) send_snapshot(next_snapshot());
      drain();
    end

    if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
